// ----- sv/literal_escape_decoder_top_assert.svh -----
// assertion macros for the literal escape decoder
// used by the decode and output queue modules; no other dependencies
`ifndef LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH
`define LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LED_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LED_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LED_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define LED_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- sv/led_pkg.sv -----
// shared types, codes and decode functions for the literal escape decoder
// no dependencies
`default_nettype none
package led_pkg;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_HEX_NONE = 3'd1;
  localparam logic [2:0] ERR_UCN_SHORT = 3'd2;
  localparam logic [2:0] ERR_UCN_RANGE = 3'd3;
  localparam logic [2:0] ERR_UCN_CTRL = 3'd4;
  localparam logic [2:0] ERR_TRAIL_BSL = 3'd5;

  localparam logic [0:0] REG_CHAR_WIDTH = 1'b0;
  localparam logic [0:0] REG_CPP11_MODE = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [31:0] val;
    logic [2:0]  err;
    logic        ovf;
    logic [2:0]  len;
    logic        eor;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [5:0] char_width;
    logic       cpp11_mode;
  } cfg_t;

  function automatic res_t mk(logic [31:0] val, logic [2:0] err, logic ovf,
                              logic [2:0] len);
    res_t r;
    r.val = val;
    r.err = err;
    r.ovf = ovf;
    r.len = len;
    r.eor = 1'b0;
    return r;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hexval(logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      h = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      h = {1'b1, 4'(c - 8'h37)};
    end
    return h;
  endfunction

  // {overflow, masked value}
  function automatic logic [32:0] fit_width(logic [31:0] v, logic [5:0] cw);
    logic [31:0] m;
    logic [32:0] f;
    m = ~(32'hFFFF_FFFF << cw[4:0]);
    if (cw >= 6'd32) begin
      f = {1'b0, v};
    end else begin
      f = {|(v & ~m), v & m};
    end
    return f;
  endfunction

  function automatic res_t finish_hex(logic [31:0] acc, logic [3:0] dc, logic ovs,
                                      logic [5:0] cw);
    logic [32:0] f;
    res_t r;
    f = fit_width(acc, cw);
    if (dc == 4'd0) begin
      r = mk(32'd0, ERR_HEX_NONE, 1'b0, 3'd0);
    end else begin
      r = mk(f[31:0], ERR_OK, ovs | f[32], 3'd0);
    end
    return r;
  endfunction

  function automatic res_t finish_oct(logic [31:0] acc, logic [5:0] cw);
    logic [32:0] f;
    f = fit_width(acc, cw);
    return mk(f[31:0], ERR_OK, 1'b0, 3'd0);
  endfunction

  function automatic res_t finish_ucn(logic [31:0] v, logic [5:0] cw, logic cpp11);
    logic [2:0] len;
    res_t r;
    if (cw >= 6'd32) begin
      len = 3'd4;
    end else if (cw[4:3] == 2'd2) begin
      len = (v <= 32'hFFFF) ? 3'd2 : 3'd4;
    end else if (v < 32'h80) begin
      len = 3'd1;
    end else if (v < 32'h800) begin
      len = 3'd2;
    end else if (v < 32'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    if ((v >= 32'hD800 && v <= 32'hDFFF) || v > 32'h10FFFF) begin
      r = mk(32'd0, ERR_UCN_RANGE, 1'b0, 3'd0);
    end else if (v < 32'ha0 && v != 32'h24 && v != 32'h40 && v != 32'h60 && !cpp11) begin
      r = mk(32'd0, ERR_UCN_CTRL, 1'b0, 3'd0);
    end else begin
      r = mk(v, ERR_OK, 1'b0, len);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/led_decode.sv -----
// input register, escape state and per-byte decode logic
// depends on led_pkg and literal_escape_decoder_top_assert.svh
`default_nettype none
`include "literal_escape_decoder_top_assert.svh"
module led_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte_in,
  input  wire logic          in_last_byte,
  input  wire led_pkg::cfg_t cfg_i,
  input  wire logic          room_i,
  output led_pkg::push_t     push_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BSL  = 3'd1;
  localparam logic [2:0] PH_HEX  = 3'd2;
  localparam logic [2:0] PH_OCT  = 3'd3;
  localparam logic [2:0] PH_UCN  = 3'd4;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  dc_r, dc_nxt;
  logic        ovs_r, ovs_nxt;
  logic        long_r, long_nxt;
  logic        fire;

  logic [4:0]     hv;
  logic [31:0]    acc_hex, acc_oct;
  logic [3:0]     dc_inc;
  logic           is_oct;
  logic           pb_emit;
  logic [2:0]     pb_phase;
  led_pkg::res_t  pb_res;
  led_pkg::res_t  r0, r1;
  logic [1:0]     cnt;

  assign fire         = s1_valid_r && room_i;
  assign in_ready     = !s1_valid_r || fire;
  assign s1_valid_nxt = in_ready ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      acc_r      <= 32'd0;
      dc_r       <= 4'd0;
      ovs_r      <= 1'b0;
      long_r     <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      dc_r       <= dc_nxt;
      ovs_r      <= ovs_nxt;
      long_r     <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
      last_r <= in_last_byte;
    end
  end

  always_comb begin
    hv       = led_pkg::hexval(byte_r);
    acc_hex  = {acc_r[27:0], hv[3:0]};
    acc_oct  = {acc_r[28:0], byte_r[2:0]};
    dc_inc   = dc_r + 4'd1;
    is_oct   = byte_r inside {[8'h30:8'h37]};
    pb_emit  = !(byte_r == led_pkg::CH_BSLASH && !last_r);
    pb_phase = pb_emit ? PH_IDLE : PH_BSL;
    pb_res   = (byte_r == led_pkg::CH_BSLASH) ?
               led_pkg::mk(32'd0, led_pkg::ERR_TRAIL_BSL, 1'b0, 3'd0) :
               led_pkg::mk({24'd0, byte_r}, led_pkg::ERR_OK, 1'b0, 3'd0);

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dc_nxt    = dc_r;
    ovs_nxt   = ovs_r;
    long_nxt  = long_r;
    cnt       = 2'd0;
    r0        = led_pkg::mk(32'd0, led_pkg::ERR_OK, 1'b0, 3'd0);
    r1        = pb_res;

    if (fire) begin
      case (phase_r)
        PH_BSL: begin
          phase_nxt = PH_IDLE;
          cnt       = 2'd1;
          case (byte_r)
            8'h61: r0 = led_pkg::mk(32'd7, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h62: r0 = led_pkg::mk(32'd8, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h65, 8'h45: r0 = led_pkg::mk(32'd27, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h66: r0 = led_pkg::mk(32'd12, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h6e: r0 = led_pkg::mk(32'd10, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h72: r0 = led_pkg::mk(32'd13, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h74: r0 = led_pkg::mk(32'd9, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h76: r0 = led_pkg::mk(32'd11, led_pkg::ERR_OK, 1'b0, 3'd0);
            8'h78: begin
              acc_nxt = 32'd0;
              dc_nxt  = 4'd0;
              ovs_nxt = 1'b0;
              if (last_r) begin
                r0 = led_pkg::mk(32'd0, led_pkg::ERR_HEX_NONE, 1'b0, 3'd0);
              end else begin
                phase_nxt = PH_HEX;
                cnt       = 2'd0;
              end
            end
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37: begin
              acc_nxt = {29'd0, byte_r[2:0]};
              dc_nxt  = 4'd1;
              if (last_r) begin
                r0 = led_pkg::finish_oct({29'd0, byte_r[2:0]}, cfg_i.char_width);
              end else begin
                phase_nxt = PH_OCT;
                cnt       = 2'd0;
              end
            end
            8'h75, 8'h55: begin
              acc_nxt  = 32'd0;
              dc_nxt   = 4'd0;
              long_nxt = byte_r[5] == 1'b0;
              if (last_r) begin
                r0 = led_pkg::mk(32'd0, led_pkg::ERR_UCN_SHORT, 1'b0, 3'd0);
              end else begin
                phase_nxt = PH_UCN;
                cnt       = 2'd0;
              end
            end
            default: r0 = led_pkg::mk({24'd0, byte_r}, led_pkg::ERR_OK, 1'b0, 3'd0);
          endcase
        end
        PH_HEX: begin
          if (hv[4]) begin
            acc_nxt = acc_hex;
            ovs_nxt = ovs_r | (|acc_r[31:28]);
            dc_nxt  = (dc_r == 4'd15) ? dc_r : dc_inc;
            if (last_r) begin
              phase_nxt = PH_IDLE;
              cnt       = 2'd1;
              r0 = led_pkg::finish_hex(acc_hex, dc_nxt, ovs_nxt, cfg_i.char_width);
            end
          end else begin
            phase_nxt = pb_phase;
            cnt       = pb_emit ? 2'd2 : 2'd1;
            r0 = led_pkg::finish_hex(acc_r, dc_r, ovs_r, cfg_i.char_width);
          end
        end
        PH_OCT: begin
          if (is_oct && dc_r < 4'd3) begin
            acc_nxt = acc_oct;
            dc_nxt  = dc_inc;
            if (dc_inc >= 4'd3 || last_r) begin
              phase_nxt = PH_IDLE;
              cnt       = 2'd1;
              r0        = led_pkg::finish_oct(acc_oct, cfg_i.char_width);
            end
          end else begin
            phase_nxt = pb_phase;
            cnt       = pb_emit ? 2'd2 : 2'd1;
            r0        = led_pkg::finish_oct(acc_r, cfg_i.char_width);
          end
        end
        PH_UCN: begin
          if (hv[4]) begin
            acc_nxt = acc_hex;
            dc_nxt  = dc_inc;
            if (dc_inc >= (long_r ? 4'd8 : 4'd4)) begin
              phase_nxt = PH_IDLE;
              cnt       = 2'd1;
              r0 = led_pkg::finish_ucn(acc_hex, cfg_i.char_width, cfg_i.cpp11_mode);
            end else if (last_r) begin
              phase_nxt = PH_IDLE;
              cnt       = 2'd1;
              r0 = led_pkg::mk(32'd0, led_pkg::ERR_UCN_SHORT, 1'b0, 3'd0);
            end
          end else begin
            phase_nxt = pb_phase;
            cnt       = pb_emit ? 2'd2 : 2'd1;
            r0 = led_pkg::mk(32'd0, led_pkg::ERR_UCN_SHORT, 1'b0, 3'd0);
          end
        end
        default: begin
          phase_nxt = pb_phase;
          cnt       = pb_emit ? 2'd1 : 2'd0;
          r0        = pb_res;
        end
      endcase
    end

    r0.eor     = (cnt == 2'd1);
    r1.eor     = 1'b1;
    push_o.cnt = cnt;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  `LED_ASSERT_IMP(a_two_only_mid_escape, clk, rst_n, push_o.cnt == 2'd2, phase_r == PH_HEX || phase_r == PH_OCT || phase_r == PH_UCN)
  `LED_ASSERT_NXT(a_last_ends_escape, clk, rst_n, fire && last_r, phase_r == PH_IDLE)
  `LED_ASSERT_IMP(a_push_needs_item, clk, rst_n, push_o.cnt != 2'd0, fire)

endmodule
`default_nettype wire

// ----- sv/led_out_queue.sv -----
// four-entry result queue, takes up to two results per cycle, gives one while out_ready is high
// depends on led_pkg and literal_escape_decoder_top_assert.svh
`default_nettype none
`include "literal_escape_decoder_top_assert.svh"
module led_out_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire led_pkg::push_t push_i,
  output logic                room_o,
  output logic                out_valid,
  input  wire logic           out_ready,
  output led_pkg::res_t       head_o
);

  led_pkg::res_t q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid  = count_r != 3'd0;
  assign pop        = out_valid && out_ready;
  assign room_o     = count_r <= 3'd2;
  assign head_o     = q_r[rd_ptr_r];
  assign wr_ptr_nxt = wr_ptr_r + push_i.cnt;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push_i.r1;
    end
  end

  `LED_ASSERT_IMP(a_push_has_room, clk, rst_n, push_i.cnt != 2'd0, count_r <= 3'd2)
  `LED_ASSERT_NXT(a_empty_stays_empty, clk, rst_n, count_r == 3'd0 && push_i.cnt == 2'd0, !out_valid)
  `LED_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, count_r <= 3'd4)

endmodule
`default_nettype wire

// ----- sv/literal_escape_decoder_top.sv -----
// path: each byte is held in the input register, then its results enter the output queue
// throughput: one byte per cycle; a byte that closes an escape and also yields
// itself gives two results, delivered one after the other from a
// four-entry queue, and input stalls while fewer than two entries are free
// reset (synchronous, active low): idle outside any escape, queue empty,
// char_width 8, cpp11_mode 1
`default_nettype none
module literal_escape_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_char_value,
  output logic [2:0]       out_error_code,
  output logic             out_overflow,
  output logic [2:0]       out_encoded_len,
  output logic             out_end_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic [5:0]     char_width_r;
  logic           cpp11_r;
  led_pkg::cfg_t  cfg;
  led_pkg::push_t push;
  led_pkg::res_t  head;
  logic           room;

  assign cfg_ready      = 1'b1;
  assign cfg.char_width = char_width_r;
  assign cfg.cpp11_mode = cpp11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_width_r <= 6'd8;
      cpp11_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == led_pkg::REG_CHAR_WIDTH) begin
        char_width_r <= cfg_data;
      end else if (cfg_index == led_pkg::REG_CPP11_MODE) begin
        cpp11_r <= cfg_data[0];
      end
    end
  end

  led_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .cfg_i        (cfg),
    .room_i       (room),
    .push_o       (push)
  );

  led_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .room_o    (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_o    (head)
  );

  assign out_char_value  = head.val;
  assign out_error_code  = head.err;
  assign out_overflow    = head.ovf;
  assign out_encoded_len = head.len;
  assign out_end_of_run  = head.eor;

endmodule
`default_nettype wire
